@@ sv/cda_pkg.sv @@
// Shared types, codes and calendar helper functions for the date unit.
package cda_pkg;

  localparam logic [13:0] YearMax = 14'd9999;
  localparam logic [3:0]  MonthMax = 4'd12;

  // Operation codes.
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_SUB  = 2'd1;
  localparam logic [1:0] OP_DIST = 2'd2;
  localparam logic [1:0] OP_CMP  = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_DATE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  // Order codes.
  localparam logic [1:0] ORD_EQ     = 2'd0;
  localparam logic [1:0] ORD_BEFORE = 2'd1;
  localparam logic [1:0] ORD_AFTER  = 2'd2;

  // 5243 / 2^19 is slightly above 1/100 and exact enough for 14-bit years.
  localparam logic [26:0] Recip100 = 27'd5243;

  typedef struct packed {
    logic load;      // capture the accepted item
    logic pre;       // leap flags and century quotients
    logic eval;      // validity, ordinal days, year bases, walk setup
    logic sum;       // day numbers
    logic span;      // distance and order
    logic walk;      // one month step of add or subtract
    logic out_load;  // move the result into the output register
  } cda_cmd_t;

  typedef struct packed {
    logic need_walk;
    logic walk_end;
  } cda_sts_t;

  function automatic logic [26:0] recip100_mul(input logic [13:0] y);
    return {13'd0, y} * Recip100;
  endfunction

  function automatic logic [7:0] div100(input logic [13:0] y);
    logic [26:0] p;
    p = recip100_mul(y);
    return p[26:19];
  endfunction

  // A multiple of 100 leaves only 12*q in the low product bits; any other
  // value leaves at least 5243 there.
  function automatic logic is_leap(input logic [13:0] y);
    logic [26:0] p;
    logic        by100;
    p     = recip100_mul(y);
    by100 = (p[18:0] < 19'd4096);
    return (y[1:0] == 2'b00) && (!by100 || (p[20:19] == 2'b00));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                     len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  function automatic logic [8:0] ordinal(input logic [3:0] m, input logic [4:0] d,
                                         input logic leap);
    logic bump;
    bump = leap && (m > 4'd2);
    return days_before(m) + {8'd0, bump} + {4'd0, d};
  endfunction

  function automatic logic date_ok(input logic [13:0] y, input logic [3:0] m,
                                   input logic [4:0] d, input logic leap);
    return (y >= 14'd1) && (y <= YearMax) && (m >= 4'd1) && (m <= MonthMax) &&
           (d >= 5'd1) && (d <= month_len(m, leap));
  endfunction

  // Days contributed by all years before y, plus 365: 365*y + p/4 - p/100 + p/400.
  function automatic logic [21:0] year_base(input logic [13:0] y, input logic [7:0] q);
    logic [13:0] p;
    p = y - 14'd1;
    return ({8'd0, y} * 22'd365) + {10'd0, p[13:2]} - {14'd0, q} + {16'd0, q[7:2]};
  endfunction

endpackage

@@ sv/calendar_date_arithmetic.sv @@
// Top level of the Gregorian date unit: add, subtract, distance and compare.
//
// Input channel: in_valid_i/in_ready_o with op, date A, date B and a day count.
// Output channel: out_valid_o/out_ready_i with the result date, distance,
// day of year of A, order and status. One result item per input item.
// Ready on the input is high only while no item is in work; one item is
// processed at a time. The finished result sits in an output register, so
// the next item is taken while that result still waits for the receiver.
// After acceptance an item passes the pre, eval, sum and distance states.
// Add and subtract then enter the month walk, one month per cycle; distance,
// compare and failed items go straight to the final state. The result of an
// add or subtract with a count of 65535 lies up to about 2160 months from A.
// If the receiver stalls, a finished item waits in its final state until
// the output register is free; no result is ever dropped.
// Reset empties the pipeline and clears the output valid flag; there is no
// other state to restore.
module calendar_date_arithmetic (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [13:0] year_a_i,
  input  logic [3:0]  month_a_i,
  input  logic [4:0]  day_a_i,
  input  logic [13:0] year_b_i,
  input  logic [3:0]  month_b_i,
  input  logic [4:0]  day_b_i,
  input  logic [15:0] day_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [13:0] res_year_o,
  output logic [3:0]  res_month_o,
  output logic [4:0]  res_day_o,
  output logic [21:0] distance_o,
  output logic [8:0]  day_of_year_o,
  output logic [1:0]  order_o,
  output logic [1:0]  status_o
);
  import cda_pkg::*;

  cda_cmd_t cmd;
  cda_sts_t sts;

  cda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cda_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (op_i),
    .year_a_i      (year_a_i),
    .month_a_i     (month_a_i),
    .day_a_i       (day_a_i),
    .year_b_i      (year_b_i),
    .month_b_i     (month_b_i),
    .day_b_i       (day_b_i),
    .day_count_i   (day_count_i),
    .res_year_o    (res_year_o),
    .res_month_o   (res_month_o),
    .res_day_o     (res_day_o),
    .distance_o    (distance_o),
    .day_of_year_o (day_of_year_o),
    .order_o       (order_o),
    .status_o      (status_o)
  );

endmodule

@@ sv/cda_ctrl.sv @@
// Sequencing state machine of the date unit.
module cda_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  cda_pkg::cda_sts_t sts_i,
  output cda_pkg::cda_cmd_t cmd_o
);
  import cda_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_EVAL,
    S_SUM,
    S_DIST,
    S_WALK,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.pre      = (state_q == S_PRE);
    cmd_o.eval     = (state_q == S_EVAL);
    cmd_o.sum      = (state_q == S_SUM);
    cmd_o.span     = (state_q == S_DIST);
    cmd_o.walk     = (state_q == S_WALK);
    cmd_o.out_load = (state_q == S_FINISH) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_PRE;
        end
        S_PRE:  state_q <= S_EVAL;
        S_EVAL: state_q <= S_SUM;
        S_SUM:  state_q <= S_DIST;
        S_DIST: state_q <= sts_i.need_walk ? S_WALK : S_FINISH;
        S_WALK: begin
          if (sts_i.walk_end) state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_PRE)
    else $error("accepted item did not start processing");

  a_finish_delivers : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FINISH && out_free |=> out_valid_o && state_q == S_IDLE)
    else $error("finished item was not presented");

  a_walk_only_when_needed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIST && !sts_i.need_walk |=> state_q == S_FINISH)
    else $error("month walk entered for an item that needs none");

endmodule

@@ sv/cda_dp.sv @@
// Datapath of the date unit: validity, day numbers, month walk and result register.
module cda_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cda_pkg::cda_cmd_t cmd_i,
  output cda_pkg::cda_sts_t sts_o,
  input  logic [1:0]        op_i,
  input  logic [13:0]       year_a_i,
  input  logic [3:0]        month_a_i,
  input  logic [4:0]        day_a_i,
  input  logic [13:0]       year_b_i,
  input  logic [3:0]        month_b_i,
  input  logic [4:0]        day_b_i,
  input  logic [15:0]       day_count_i,
  output logic [13:0]       res_year_o,
  output logic [3:0]        res_month_o,
  output logic [4:0]        res_day_o,
  output logic [21:0]       distance_o,
  output logic [8:0]        day_of_year_o,
  output logic [1:0]        order_o,
  output logic [1:0]        status_o
);
  import cda_pkg::*;

  // Captured item.
  logic [1:0]  op_q;
  logic [13:0] ya_q, yb_q;
  logic [3:0]  ma_q, mb_q;
  logic [4:0]  da_q, db_q;
  logic [15:0] cnt_q;

  // Intermediate values.
  logic        leap_a_q, leap_b_q;
  logic [7:0]  qa_q, qb_q;
  logic        a_ok_q, b_ok_q;
  logic [8:0]  doy_a_q, doy_b_q;
  logic [21:0] base_a_q, base_b_q;
  logic [21:0] na_q, nb_q;
  logic [21:0] dist_q;
  logic [1:0]  ord_q;

  // Month walk.
  logic [13:0]        walk_y_q;
  logic [3:0]         walk_m_q;
  logic signed [17:0] walk_d_q;
  logic               walk_leap_q;
  logic               ovf_q;

  // Result register.
  logic [13:0] res_year_q;
  logic [3:0]  res_month_q;
  logic [4:0]  res_day_q;
  logic [21:0] distance_q;
  logic [8:0]  doy_q;
  logic [1:0]  order_q;
  logic [1:0]  status_q;

  logic               is_sub, bad;
  logic [4:0]         cur_len, prev_len;
  logic [3:0]         prev_m;
  logic signed [17:0] cur_len_s, prev_len_s;
  logic               fwd_more, back_more, ovf_add, ovf_sub, walk_end;
  logic [22:0]        key_a, key_b;
  logic [1:0]         status_d;
  logic               take_walk;
  logic [21:0]        distance_d;

  assign is_sub     = (op_q == OP_SUB);
  assign bad        = !a_ok_q || (op_q[1] && !b_ok_q);

  assign cur_len    = month_len(walk_m_q, walk_leap_q);
  assign prev_m     = (walk_m_q == 4'd1) ? MonthMax : walk_m_q - 4'd1;
  // The year only changes between December and January, so the leap flag
  // of the walk year is always current by the time February is reached.
  assign prev_len   = month_len(prev_m, walk_leap_q);
  assign cur_len_s  = signed'({13'd0, cur_len});
  assign prev_len_s = signed'({13'd0, prev_len});

  assign fwd_more   = walk_d_q > cur_len_s;
  assign back_more  = walk_d_q < 18'sd1;
  assign ovf_add    = fwd_more && (walk_m_q == MonthMax) && (walk_y_q == YearMax);
  assign ovf_sub    = back_more && (walk_m_q == 4'd1) && (walk_y_q == 14'd1);
  assign walk_end   = is_sub ? (!back_more || ovf_sub) : (!fwd_more || ovf_add);

  assign sts_o.need_walk = !bad && !op_q[1];
  assign sts_o.walk_end  = walk_end;

  assign key_a = {ya_q, ma_q, da_q};
  assign key_b = {yb_q, mb_q, db_q};

  always_comb begin
    if (bad) begin
      status_d = ST_BAD_DATE;
    end else if (!op_q[1] && ovf_q) begin
      status_d = ST_RANGE;
    end else begin
      status_d = ST_OK;
    end
  end

  assign take_walk  = (status_d == ST_OK) && !op_q[1];
  assign distance_d = (status_d == ST_OK && op_q == OP_DIST) ? dist_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      ya_q  <= year_a_i;
      ma_q  <= month_a_i;
      da_q  <= day_a_i;
      yb_q  <= year_b_i;
      mb_q  <= month_b_i;
      db_q  <= day_b_i;
      cnt_q <= day_count_i;
    end

    if (cmd_i.pre) begin
      leap_a_q <= is_leap(ya_q);
      leap_b_q <= is_leap(yb_q);
      qa_q     <= div100(ya_q - 14'd1);
      qb_q     <= div100(yb_q - 14'd1);
    end

    if (cmd_i.eval) begin
      a_ok_q      <= date_ok(ya_q, ma_q, da_q, leap_a_q);
      b_ok_q      <= date_ok(yb_q, mb_q, db_q, leap_b_q);
      doy_a_q     <= ordinal(ma_q, da_q, leap_a_q);
      doy_b_q     <= ordinal(mb_q, db_q, leap_b_q);
      base_a_q    <= year_base(ya_q, qa_q);
      base_b_q    <= year_base(yb_q, qb_q);
      walk_y_q    <= ya_q;
      walk_m_q    <= ma_q;
      walk_leap_q <= leap_a_q;
      ovf_q       <= 1'b0;
      if (is_sub) begin
        walk_d_q <= signed'({13'd0, da_q} - {2'd0, cnt_q});
      end else begin
        walk_d_q <= signed'({13'd0, da_q} + {2'd0, cnt_q});
      end
    end

    if (cmd_i.sum) begin
      na_q <= base_a_q + {13'd0, doy_a_q};
      nb_q <= base_b_q + {13'd0, doy_b_q};
    end

    if (cmd_i.span) begin
      dist_q <= (na_q >= nb_q) ? (na_q - nb_q) : (nb_q - na_q);
      if (key_a == key_b) begin
        ord_q <= ORD_EQ;
      end else if (key_a < key_b) begin
        ord_q <= ORD_BEFORE;
      end else begin
        ord_q <= ORD_AFTER;
      end
    end

    if (cmd_i.walk) begin
      walk_leap_q <= is_leap(walk_y_q);
      ovf_q       <= is_sub ? ovf_sub : ovf_add;
      if (!walk_end) begin
        if (is_sub) begin
          walk_d_q <= walk_d_q + prev_len_s;
          walk_m_q <= prev_m;
          if (walk_m_q == 4'd1) walk_y_q <= walk_y_q - 14'd1;
        end else begin
          walk_d_q <= walk_d_q - cur_len_s;
          if (walk_m_q == MonthMax) begin
            walk_m_q <= 4'd1;
            walk_y_q <= walk_y_q + 14'd1;
          end else begin
            walk_m_q <= walk_m_q + 4'd1;
          end
        end
      end
    end

    if (cmd_i.out_load) begin
      res_year_q  <= take_walk ? walk_y_q : ya_q;
      res_month_q <= take_walk ? walk_m_q : ma_q;
      res_day_q   <= take_walk ? walk_d_q[4:0] : da_q;
      distance_q  <= distance_d;
      doy_q       <= a_ok_q ? doy_a_q : '0;
      order_q     <= (status_d == ST_OK && op_q == OP_CMP) ? ord_q : ORD_EQ;
      status_q    <= status_d;
    end
  end

  assign res_year_o    = res_year_q;
  assign res_month_o   = res_month_q;
  assign res_day_o     = res_day_q;
  assign distance_o    = distance_q;
  assign day_of_year_o = doy_q;
  assign order_o       = order_q;
  assign status_o      = status_q;

  a_range_only_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load && status_d == ST_RANGE |-> !op_q[1])
    else $error("range status given for an operation without a walk");

  a_walk_month_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk |-> walk_m_q >= 4'd1 && walk_m_q <= MonthMax)
    else $error("walk month left 1..12");

  a_distance_only_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load && distance_d != '0 |-> op_q == OP_DIST && status_d == ST_OK)
    else $error("nonzero distance for an item that is not a good distance");

endmodule
